[rtl/pfsoc_pkg.sv]
// Shared types, constants and filter coefficients for the prefiltered second-order controller.
package pfsoc_pkg;

    localparam int SIG_FRAC   = 16;
    localparam int COEF_FRAC  = 20;

    localparam int ADC_W      = 10;
    localparam int ADC_FULL   = 1023;
    localparam int VOLT_W     = 19;
    localparam int OPND_W     = VOLT_W + 1;
    localparam int TICK_W     = 11;
    localparam int OFFSET_W   = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam int FIVE_V     = 5 << SIG_FRAC;
    // volts per code times 1024: adc * 5 * 2^S / 1023 = gain * adc * 1024 / 1023
    localparam int MEAS_GAIN  = FIVE_V / 1024;

    localparam int NUM_TAPS   = 5;
    localparam int COEF_W     = 24;
    localparam int TERM_W     = COEF_W + 3;
    localparam int ACC_W      = 46;
    localparam int BIT_CNT_W  = $clog2(OPND_W);

    // tap order: a1 on y[n-1], a2 on y[n-2], b0, b1, b2 on x[n], x[n-1], x[n-2]
    localparam logic [NUM_TAPS-1:0] TAP_NEG = 5'b01010;

    typedef logic [COEF_W-1:0] coef_t;
    typedef logic [NUM_TAPS-1:0][COEF_W-1:0] coef_set_t;
    typedef logic [OPND_W-1:0] opnd_t;

    function automatic coef_t q28_to_coef(input longint q28);
        longint t;
        t = (((q28 * 2) >>> (28 - COEF_FRAC)) + 1) >>> 1;
        return t[COEF_W-1:0];
    endfunction

    localparam coef_set_t PF_COEF = {
        q28_to_coef(64'sd71698813),  q28_to_coef(64'sd149650667),
        q28_to_coef(64'sd78896526),  q28_to_coef(64'sd232454185),
        q28_to_coef(64'sd499937674)
    };

    localparam coef_set_t CT_COEF = {
        q28_to_coef(64'sd526401929), q28_to_coef(64'sd1131992318),
        q28_to_coef(64'sd607737872), q28_to_coef(64'sd203903596),
        q28_to_coef(64'sd472339052)
    };

    typedef enum logic
    {
        MODE_PF,
        MODE_CT
    } mac_mode_t;

    typedef struct packed
    {
        logic      start;
        mac_mode_t mode;
    } mac_ctl_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_REF_LOW     = 3'd0,
        CFG_REF_HIGH    = 3'd1,
        CFG_SWITCH_TICK = 3'd2,
        CFG_PERIOD_TICK = 3'd3,
        CFG_DIST_OFFSET = 3'd4
    } cfg_index_t;

    typedef struct packed
    {
        logic [VOLT_W-1:0]   ref_low;
        logic [VOLT_W-1:0]   ref_high;
        logic [TICK_W-1:0]   switch_tick;
        logic [TICK_W-1:0]   period_tick;
        logic [OFFSET_W-1:0] dist_offset;
    } cfg_regs_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_PF,
        ST_CT,
        ST_DELIVER
    } ctl_state_t;

endpackage

[rtl/pfsoc_cfg.sv]
// Configuration register file with index decode.
module pfsoc_cfg import pfsoc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_regs_t             regs
);

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_REF_LOW:     regs_next.ref_low     = cfg_data[VOLT_W-1:0];
                CFG_REF_HIGH:    regs_next.ref_high    = cfg_data[VOLT_W-1:0];
                CFG_SWITCH_TICK: regs_next.switch_tick = cfg_data[TICK_W-1:0];
                CFG_PERIOD_TICK: regs_next.period_tick = cfg_data[TICK_W-1:0];
                CFG_DIST_OFFSET: regs_next.dist_offset = cfg_data[OFFSET_W-1:0];
                default:         regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.ref_low     <= VOLT_W'(65536);
            regs_reg.ref_high    <= VOLT_W'(262144);
            regs_reg.switch_tick <= TICK_W'(625);
            regs_reg.period_tick <= TICK_W'(1250);
            regs_reg.dist_offset <= OFFSET_W'(32768);
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    a_period_kept: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_valid |=> regs_reg.period_tick == $past(regs_reg.period_tick))
        else $error("period register changed without a write");

    a_bad_index_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_index > CFG_IDX_W'(CFG_DIST_OFFSET) |=> $stable(regs_reg))
        else $error("write to unknown index altered the registers");

    a_ref_written: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_index == CFG_IDX_W'(CFG_REF_HIGH)
        |=> regs_reg.ref_high == $past(cfg_data[VOLT_W-1:0]))
        else $error("reference high write lost");

endmodule

[rtl/pfsoc_mac.sv]
// Bit-serial five-tap multiply-accumulate with rounding and 0..5 V clamp.
module pfsoc_mac import pfsoc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mac_ctl_t                   ctl,
    input  opnd_t [NUM_TAPS-1:0]       opnd,
    output logic                       done,
    output logic [VOLT_W-1:0]          result
);

    opnd_t [NUM_TAPS-1:0]      sh_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic [BIT_CNT_W-1:0]      cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    mac_mode_t                 mode_reg;

    coef_set_t                 coef_set;
    logic signed [TERM_W-1:0]  term;
    logic signed [TERM_W-1:0]  term_w;
    logic signed [ACC_W-1:0]   rnd;
    logic signed [ACC_W-1:0]   quo;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [ACC_W-1:0] FIVE_ACC   = ACC_W'(FIVE_V);

    assign coef_set = (mode_reg == MODE_CT) ? CT_COEF : PF_COEF;

    // Horner over operand bits, MSB first; the first bit is the two's complement sign
    always_comb
    begin
        term = '0;
        for (int k = 0; k < NUM_TAPS; k++)
        begin
            if (sh_reg[k][OPND_W-1])
            begin
                if (TAP_NEG[k])
                    term = term - TERM_W'(coef_set[k]);
                else
                    term = term + TERM_W'(coef_set[k]);
            end
        end
        term_w   = (cnt_reg == BIT_CNT_W'(OPND_W - 1)) ? -term : term;
        acc_next = (acc_reg <<< 1) + {{(ACC_W - TERM_W){term_w[TERM_W-1]}}, term_w};
    end

    always_comb
    begin
        rnd = acc_reg + ROUND_HALF;
        quo = rnd >>> COEF_FRAC;
        if (quo[ACC_W-1])
            result = '0;
        else if (quo > FIVE_ACC)
            result = VOLT_W'(FIVE_V);
        else
            result = quo[VOLT_W-1:0];
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= MODE_PF;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0) && !ctl.start;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= BIT_CNT_W'(OPND_W - 1);
                mode_reg <= ctl.mode;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            sh_reg  <= opnd;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            for (int k = 0; k < NUM_TAPS; k++)
                sh_reg[k] <= sh_reg[k] << 1;
            acc_reg <= acc_next;
        end
    end

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |=> busy_reg && cnt_reg == BIT_CNT_W'(OPND_W - 1))
        else $error("MAC did not start a pass");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && cnt_reg == '0 && !ctl.start |=> done_reg && !busy_reg)
        else $error("MAC pass did not finish");

    a_result_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> result <= VOLT_W'(FIVE_V))
        else $error("MAC result above 5 V");

endmodule

[rtl/prefiltered_second_order_controller.sv]
// Top level: sequencer, tick logic, filter histories and result register.
//
// One request on the input channel (in_valid/in_ready) carries a 10-bit ADC
// reading; it yields exactly one result on the output channel
// (out_valid/out_ready) with drive, filtered reference, error, echo and the
// disturbance flag. Configuration writes arrive on cfg_valid/cfg_ready with a
// register index and data; cfg_ready is always high and writes are meant to
// land while no request is in flight.
// Each request takes two passes of the bit-serial MAC, 20 operand bits each,
// and then loads the result register. The next request is taken in the
// cycle after that; the single shared MAC takes no new request before the
// last one is through.
// The result register is apart from the datapath: a new request is accepted
// while an earlier result still waits. If the receiver stalls, the finished
// result is held in the MAC until the register frees.
// Reset clears the tick counter, flags and all filter histories and loads
// the configuration defaults; the block is ready in the first cycle after.
module prefiltered_second_order_controller import pfsoc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ADC_W-1:0]      adc_sample,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VOLT_W-1:0]     drive_value,
    output logic [VOLT_W-1:0]     filtered_reference,
    output logic signed [OPND_W-1:0] control_error,
    output logic [ADC_W-1:0]      sample_echo,
    output logic                  disturbance_active,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_regs_t                cfg;
    ctl_state_t               state_reg;
    ctl_state_t               state_next;
    mac_ctl_t                 mac_ctl;
    opnd_t [NUM_TAPS-1:0]     mac_opnd;
    logic                     mac_done;
    logic [VOLT_W-1:0]        mac_result;

    logic                     accept;
    logic                     pf_fire;
    logic                     out_load;

    logic [TICK_W-1:0]        cnt_reg;
    logic [TICK_W-1:0]        cnt_inc;
    logic                     sel_reg;
    logic                     sel_next;
    logic                     dist_reg;
    logic                     dist_next;
    logic                     hit_switch;
    logic                     hit_period;
    logic [VOLT_W-1:0]        step_now;

    logic [VOLT_W-1:0]        ref_d1_reg;
    logic [VOLT_W-1:0]        ref_d2_reg;
    logic [VOLT_W-1:0]        y_d1_reg;
    logic [VOLT_W-1:0]        y_d2_reg;
    logic signed [OPND_W-1:0] err_d1_reg;
    logic signed [OPND_W-1:0] err_d2_reg;
    logic [VOLT_W-1:0]        u_d1_reg;
    logic [VOLT_W-1:0]        u_d2_reg;
    logic signed [OPND_W-1:0] e_now;

    logic [ADC_W-1:0]         adc_reg;
    logic [VOLT_W-1:0]        meas_reg;
    logic [VOLT_W-1:0]        meas_base;
    logic [VOLT_W-1:0]        meas_round;
    logic [VOLT_W-ADC_W-1:0]  meas_hi;
    logic [ADC_W:0]           meas_sum;
    logic                     meas_carry;
    logic [VOLT_W-1:0]        meas_now;

    logic                     out_valid_reg;
    logic [VOLT_W-1:0]        drive_reg;
    logic [VOLT_W-1:0]        fref_reg;
    logic signed [OPND_W-1:0] err_out_reg;
    logic [ADC_W-1:0]         echo_reg;
    logic                     dist_out_reg;
    logic [VOLT_W:0]          drive_sum;

    pfsoc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (cfg)
    );

    pfsoc_mac u_mac
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .opnd   (mac_opnd),
        .done   (mac_done),
        .result (mac_result)
    );

    assign accept = in_valid && in_ready;

    // tick counter and flags; the new flags govern this request
    always_comb
    begin
        cnt_inc    = cnt_reg + 1'b1;
        hit_switch = (cnt_inc == cfg.switch_tick);
        hit_period = (cnt_inc == cfg.period_tick);
        sel_next   = sel_reg ^ hit_switch;
        dist_next  = dist_reg ^ hit_period;
        step_now   = sel_next ? cfg.ref_high : cfg.ref_low;
    end

    // adc * 5 V / 1023: split 1024/1023 as 1 + 1/1023, one compare corrects the quotient
    always_comb
    begin
        meas_base  = VOLT_W'(adc_sample * MEAS_GAIN);
        meas_round = meas_base + VOLT_W'(ADC_FULL / 2);
        meas_hi    = meas_round[VOLT_W-1:ADC_W];
        meas_sum   = (ADC_W + 1)'(meas_hi) + {1'b0, meas_round[ADC_W-1:0]};
        meas_carry = (meas_sum >= (ADC_W + 1)'(ADC_FULL));
        meas_now   = meas_base + VOLT_W'(meas_hi) + VOLT_W'(meas_carry);
    end

    assign e_now = $signed({1'b0, mac_result}) - $signed({1'b0, meas_reg});

    always_comb
    begin
        if (state_reg == ST_PF)
        begin
            mac_opnd[0] = {1'b0, u_d1_reg};
            mac_opnd[1] = {1'b0, u_d2_reg};
            mac_opnd[2] = e_now;
            mac_opnd[3] = err_d1_reg;
            mac_opnd[4] = err_d2_reg;
        end
        else
        begin
            mac_opnd[0] = {1'b0, y_d1_reg};
            mac_opnd[1] = {1'b0, y_d2_reg};
            mac_opnd[2] = {1'b0, step_now};
            mac_opnd[3] = {1'b0, ref_d1_reg};
            mac_opnd[4] = {1'b0, ref_d2_reg};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_PF;
            end
            ST_PF:
            begin
                if (mac_done)
                    state_next = ST_CT;
            end
            ST_CT:
            begin
                if (mac_done)
                    state_next = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        mac_ctl.start = 1'b0;
        mac_ctl.mode  = MODE_PF;
        pf_fire       = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                mac_ctl.start = in_valid;
            end
            ST_PF:
            begin
                mac_ctl.mode  = MODE_CT;
                mac_ctl.start = mac_done;
                pf_fire       = mac_done;
            end
            ST_CT:
            begin
                mac_ctl.mode = MODE_CT;
            end
            ST_DELIVER:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sel_reg       <= 1'b0;
            dist_reg      <= 1'b0;
            ref_d1_reg    <= '0;
            ref_d2_reg    <= '0;
            y_d1_reg      <= '0;
            y_d2_reg      <= '0;
            err_d1_reg    <= '0;
            err_d2_reg    <= '0;
            u_d1_reg      <= '0;
            u_d2_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg    <= hit_period ? '0 : cnt_inc;
                sel_reg    <= sel_next;
                dist_reg   <= dist_next;
                ref_d2_reg <= ref_d1_reg;
                ref_d1_reg <= step_now;
            end
            if (pf_fire)
            begin
                y_d2_reg   <= y_d1_reg;
                y_d1_reg   <= mac_result;
                err_d2_reg <= err_d1_reg;
                err_d1_reg <= e_now;
            end
            if (out_load)
            begin
                u_d2_reg <= u_d1_reg;
                u_d1_reg <= mac_result;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign drive_sum = {1'b0, mac_result}
                     + (dist_reg ? (VOLT_W + 1)'(cfg.dist_offset) : '0);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            adc_reg  <= adc_sample;
            meas_reg <= meas_now;
        end
        if (out_load)
        begin
            drive_reg    <= drive_sum[VOLT_W-1:0];
            fref_reg     <= y_d1_reg;
            err_out_reg  <= err_d1_reg;
            echo_reg     <= adc_reg;
            dist_out_reg <= dist_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign drive_value        = drive_reg;
    assign filtered_reference = fref_reg;
    assign control_error      = err_out_reg;
    assign sample_echo        = echo_reg;
    assign disturbance_active = dist_out_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while one is in flight");

    a_done_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == ST_PF || state_reg == ST_CT))
        else $error("MAC finished outside a filter pass");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid && filtered_reference <= VOLT_W'(FIVE_V))
        else $error("result register not loaded correctly");

endmodule

[sim/tb_prefiltered_second_order_controller.sv]
// Self-checking testbench for the prefiltered second-order controller.
`timescale 1ns / 100ps

module tb_prefiltered_second_order_controller import pfsoc_pkg::*;;

    localparam int     SIG_FRAC_BITS  = 16;
    localparam int     COEF_FRAC_BITS = 20;
    localparam longint FIVE_VOLTS     = 64'd5 << SIG_FRAC_BITS;
    localparam int     MAX_LEVEL      = 2 ** VOLT_W - 1;
    localparam int     MAX_TICK       = 2 ** TICK_W - 1;
    localparam int     MAX_OFFSET     = 2 ** OFFSET_W - 1;
    localparam int     RESET_CYCLES   = 10;
    localparam int     SETTLE_CYCLES  = 4;
    localparam int     FINAL_CYCLES   = 100;
    localparam int     LONG_HOLD      = 600;
    localparam int     LIMIT_CYCLES   = 1_000_000;
    localparam int     LONG_RUN_ITEMS = 900;

    // tap order a1, a2, b0, b1, b2; coefficients given scaled by 2^28
    localparam longint PF_Q28[5] = '{499937674, 232454185, 78896526, 149650667, 71698813};
    localparam longint CT_Q28[5] = '{472339052, 203903596, 607737872, 1131992318, 526401929};

    typedef struct {
        logic [VOLT_W-1:0]        drive;
        logic [VOLT_W-1:0]        fref;
        logic signed [OPND_W-1:0] err;
        logic [ADC_W-1:0]         echo;
        logic                     dist_flag;
    } tick_result_t;

    class ctrl_scoreboard;
        logic [VOLT_W-1:0]   ref_low;
        logic [VOLT_W-1:0]   ref_high;
        logic [TICK_W-1:0]   switch_at;
        logic [TICK_W-1:0]   period_at;
        logic [OFFSET_W-1:0] offset;
        logic [TICK_W-1:0]   tick_count;
        logic                high_sel;
        logic                dist_on;
        longint              ref_hist[3];
        longint              pf_hist[2];
        longint              err_hist[3];
        longint              drive_hist[2];
        longint              coef[2][5];
        tick_result_t        expected_ticks[$];
        int                  mismatch_count;

        function new();
            for (int i = 0; i < 5; i++)
            begin
                coef[MODE_PF][i] = round_half_up(PF_Q28[i], 28 - COEF_FRAC_BITS);
                coef[MODE_CT][i] = round_half_up(CT_Q28[i], 28 - COEF_FRAC_BITS);
            end
            ref_low    = VOLT_W'(65536);
            ref_high   = VOLT_W'(262144);
            switch_at  = TICK_W'(625);
            period_at  = TICK_W'(1250);
            offset     = OFFSET_W'(32768);
            tick_count = '0;
            high_sel   = 1'b0;
            dist_on    = 1'b0;
            ref_hist   = '{0, 0, 0};
            pf_hist    = '{0, 0};
            err_hist   = '{0, 0, 0};
            drive_hist = '{0, 0};
            mismatch_count = 0;
        endfunction

        // floor((s + 2^(k-1)) / 2^k)
        function longint round_half_up(longint s, int k);
            return (s + (longint'(1) <<< (k - 1))) >>> k;
        endfunction

        function longint second_order(mac_mode_t mode, longint y1, longint y2,
                                      longint x0, longint x1, longint x2);
            longint acc;
            acc = coef[mode][0] * y1 - coef[mode][1] * y2 + coef[mode][2] * x0
                - coef[mode][3] * x1 + coef[mode][4] * x2;
            acc = round_half_up(acc, COEF_FRAC_BITS);
            if (acc < 0)
                acc = 0;
            else if (acc > FIVE_VOLTS)
                acc = FIVE_VOLTS;
            return acc;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_REF_LOW:     ref_low   = data[VOLT_W-1:0];
                CFG_REF_HIGH:    ref_high  = data[VOLT_W-1:0];
                CFG_SWITCH_TICK: switch_at = data[TICK_W-1:0];
                CFG_PERIOD_TICK: period_at = data[TICK_W-1:0];
                CFG_DIST_OFFSET: offset    = data[OFFSET_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [ADC_W-1:0] adc);
            longint       level;
            longint       filt;
            longint       meas;
            longint       err;
            longint       drive;
            tick_result_t r;
            // counter and flags move first, the new flags apply to this tick
            tick_count = tick_count + 1'b1;
            if (tick_count == switch_at)
                high_sel = !high_sel;
            if (tick_count == period_at)
            begin
                dist_on    = !dist_on;
                tick_count = '0;
            end
            level = high_sel ? ref_high : ref_low;
            ref_hist[2] = ref_hist[1];
            ref_hist[1] = ref_hist[0];
            ref_hist[0] = level;
            filt = second_order(MODE_PF, pf_hist[0], pf_hist[1],
                                ref_hist[0], ref_hist[1], ref_hist[2]);
            pf_hist[1] = pf_hist[0];
            pf_hist[0] = filt;
            meas = (((longint'(adc) * 5) << SIG_FRAC_BITS) + ADC_FULL / 2) / ADC_FULL;
            err  = filt - meas;
            err_hist[2] = err_hist[1];
            err_hist[1] = err_hist[0];
            err_hist[0] = err;
            drive = second_order(MODE_CT, drive_hist[0], drive_hist[1],
                                 err_hist[0], err_hist[1], err_hist[2]);
            drive_hist[1] = drive_hist[0];
            drive_hist[0] = drive;
            if (dist_on)
                drive = drive + offset;
            r.drive     = drive[VOLT_W-1:0];
            r.fref      = filt[VOLT_W-1:0];
            r.err       = err[OPND_W-1:0];
            r.echo      = adc;
            r.dist_flag = dist_on;
            expected_ticks.push_back(r);
        endfunction

        function void field_check(string name, longint want, longint got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(tick_result_t got);
            tick_result_t want;
            if (expected_ticks.size() == 0)
            begin
                $error("result with no request pending");
                mismatch_count++;
                return;
            end
            want = expected_ticks.pop_front();
            field_check("drive_value", want.drive, got.drive);
            field_check("filtered_reference", want.fref, got.fref);
            field_check("control_error", longint'(want.err), longint'(got.err));
            field_check("sample_echo", want.echo, got.echo);
            field_check("disturbance_active", want.dist_flag, got.dist_flag);
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [ADC_W-1:0]      adc_sample = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [VOLT_W-1:0]     drive_value;
    logic [VOLT_W-1:0]     filtered_reference;
    logic signed [OPND_W-1:0] control_error;
    logic [ADC_W-1:0]      sample_echo;
    logic                  disturbance_active;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    bit                    pressure_armed = 1'b0;
    bit                    pressure_done  = 1'b0;
    int                    cycle_count    = 0;
    ctrl_scoreboard        scoreboard     = new();

    prefiltered_second_order_controller DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .adc_sample         (adc_sample),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .drive_value        (drive_value),
        .filtered_reference (filtered_reference),
        .control_error      (control_error),
        .sample_echo        (sample_echo),
        .disturbance_active (disturbance_active),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin : monitor
        tick_result_t seen;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                scoreboard.write_reg(cfg_index, cfg_data);
            if (out_valid && out_ready)
            begin
                seen.drive     = drive_value;
                seen.fref      = filtered_reference;
                seen.err       = control_error;
                seen.echo      = sample_echo;
                seen.dist_flag = disturbance_active;
                scoreboard.check_result(seen);
            end
            if (in_valid && in_ready)
                scoreboard.note_sample(adc_sample);
        end
    end

    // receiver: ready runs broken by stalls, plus one long hold-off on request
    initial
    begin : receiver
        int hold_left;
        int ready_left;
        int stall_left;
        hold_left  = 0;
        ready_left = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (pressure_armed && !pressure_done)
            begin
                hold_left     = LONG_HOLD;
                pressure_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (ready_left > 0)
            begin
                ready_left--;
                out_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                ready_left = $urandom_range(1, 60);
                stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [ADC_W-1:0] next_adc();
        int v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = ADC_FULL;
            2, 3: v = $urandom_range(0, ADC_FULL);
            // follow the drive like a sluggish plant, with some noise
            default: v = int'(scoreboard.drive_hist[0] * ADC_FULL / FIVE_VOLTS)
                         + int'($urandom_range(0, 16)) - 8;
        endcase
        if (v < 0)
            v = 0;
        else if (v > ADC_FULL)
            v = ADC_FULL;
        return v[ADC_W-1:0];
    endfunction

    function automatic logic [VOLT_W-1:0] pick_level();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return VOLT_W'(FIVE_VOLTS);
            2: return VOLT_W'(MAX_LEVEL);
            default: return VOLT_W'($urandom_range(0, int'(FIVE_VOLTS)));
        endcase
    endfunction

    function automatic logic [TICK_W-1:0] pick_tick();
        case ($urandom_range(0, 5))
            0: return TICK_W'(1);
            1: return TICK_W'(MAX_TICK);
            default: return TICK_W'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic logic [OFFSET_W-1:0] pick_offset();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return OFFSET_W'(1 << SIG_FRAC_BITS);
            2: return OFFSET_W'(MAX_OFFSET);
            default: return OFFSET_W'($urandom_range(0, MAX_OFFSET));
        endcase
    endfunction

    task automatic send_sample(input logic [ADC_W-1:0] v);
        in_valid   <= 1'b1;
        adc_sample <= v;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // junk above the field widths must be dropped, unknown indexes ignored
    task automatic apply_settings(input logic [VOLT_W-1:0] low_lvl,
                                  input logic [VOLT_W-1:0] high_lvl,
                                  input logic [TICK_W-1:0] sw,
                                  input logic [TICK_W-1:0] per,
                                  input logic [OFFSET_W-1:0] ofs);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(CFG_REF_LOW, low_lvl);
        write_reg(CFG_REF_HIGH, high_lvl);
        write_reg(CFG_SWITCH_TICK, {junk[CFG_DATA_W-1:TICK_W], sw});
        write_reg(CFG_PERIOD_TICK, {junk[CFG_DATA_W-1:TICK_W], per});
        write_reg(CFG_DIST_OFFSET, {junk[CFG_DATA_W-1:OFFSET_W], ofs});
        write_reg(CFG_IDX_W'($urandom_range(CFG_DIST_OFFSET + 1, 2 ** CFG_IDX_W - 1)), junk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (scoreboard.expected_ticks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_list(input logic [ADC_W-1:0] samples[$]);
        foreach (samples[i])
            send_sample(samples[i]);
        wait_idle();
    endtask

    task automatic run_phase(input int n_items);
        int left;
        int burst;
        int gap;
        left = n_items;
        while (left > 0)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && left > 0)
            begin
                send_sample(next_adc());
                burst--;
                left--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            if (gap != 0 && left > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        wait_idle();
    endtask

    initial
    begin : stimulus
        logic [ADC_W-1:0] directed_q[$];
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults
        directed_q = '{10'd0, 10'd1023, 10'd512};
        send_list(directed_q);

        // reference above 5 V, largest offset, fast toggling with restart
        apply_settings('0, VOLT_W'(MAX_LEVEL), TICK_W'(2), TICK_W'(4),
                       OFFSET_W'(MAX_OFFSET));
        directed_q = '{10'd1023, 10'd0, 10'd1, 10'd1022, 10'd512,
                       10'd511, 10'd341, 10'd682, 10'd0, 10'd1023};
        send_list(directed_q);

        // switch and period equal: both toggle on the same tick
        apply_settings(VOLT_W'(FIVE_VOLTS), '0, TICK_W'(3), TICK_W'(3), '0);
        directed_q = '{10'd0, 10'd0, 10'd1023, 10'd1023, 10'd256,
                       10'd768, 10'd0, 10'd1023, 10'd85, 10'd938};
        send_list(directed_q);

        // long receiver hold-off while requests keep coming
        pressure_armed = 1'b1;
        run_phase(40);

        for (int phase = 0; phase < 7; phase++)
        begin
            apply_settings(pick_level(), pick_level(), pick_tick(), pick_tick(), pick_offset());
            run_phase($urandom_range(40, 80));
        end

        // zero period is matched only when the counter wraps, so it climbs through its full range
        apply_settings(pick_level(), pick_level(), pick_tick(), '0, pick_offset());
        run_phase(LONG_RUN_ITEMS);

        repeat (FINAL_CYCLES) @(posedge clk);
        if (scoreboard.mismatch_count == 0 && scoreboard.expected_ticks.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[prefiltered_second_order_controller.f]
rtl/pfsoc_pkg.sv
rtl/pfsoc_cfg.sv
rtl/pfsoc_mac.sv
rtl/prefiltered_second_order_controller.sv
sim/tb_prefiltered_second_order_controller.sv
